### rtl/core/stepper_ramp_step_generator_core_assert.svh
// Assertion macros for the step generator core.
// Needs a clk and a synchronous active-high rst in the including module.
`ifndef STEPPER_RAMP_STEP_GENERATOR_CORE_ASSERT_SVH
`define STEPPER_RAMP_STEP_GENERATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRSG_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("step generator check failed");
`define SRSG_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("step generator check failed");
`else
`define SRSG_ASSERT_IMP(label, lhs, rhs)
`define SRSG_ASSERT_NXT(label, lhs, rhs)
`endif
`endif

### rtl/core/srsg_pkg.sv
// Shared types, constants and helpers for the stepper ramp step generator.
// No dependencies.
package srsg_pkg;

  localparam int COUNT_BITS = 24;
  localparam int TIMER_BITS = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = COUNT_BITS + 16;
  localparam int FADE_A     = (PROD_W - 7 > 25) ? PROD_W - 7 : 25;
  localparam int FADE_W     = ((FADE_A > TIMER_BITS) ? FADE_A : TIMER_BITS) + 2;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL_MAX  = 3'd0,
    REG_INTERVAL_MIN  = 3'd1,
    REG_START_ACCEL   = 3'd2,
    REG_STOP_ACCEL    = 3'd3,
    REG_REVERSE_PAUSE = 3'd4,
    REG_PULSE_WIDTH   = 3'd5,
    REG_INVERT_DIR    = 3'd6
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_REV   = 6'b000100,
    PH_WAIT  = 6'b001000,
    PH_PULSE = 6'b010000,
    PH_FADE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        func;
    logic        direction;
    logic [23:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic step_out;
    logic dir_out;
    logic enable_out_n;
    logic busy_res;
  } out_item_t;

  function automatic logic [TIMER_BITS-1:0] tclamp(input logic [23:0] v);
    logic [32:0] x;
    x = 33'(v);
    if (x > 33'(TMAX)) begin
      return TMAX;
    end
    return TIMER_BITS'(x);
  endfunction

endpackage

### rtl/core/stepper_ramp_step_generator_core.sv
// Step generator core: tick/move beats in, one status beat out per beat in.
// Each output beat is registered from its input beat; throughput 1 beat per cycle while the skid entry is empty.
// A two-entry output buffer keeps input open while one result waits.
// The deceleration product is registered each cycle from the step count.
// Reset (rst, synchronous): idle, driver disabled, registers at defaults.
// Depends on srsg_pkg and stepper_ramp_step_generator_core_assert.svh.
`include "stepper_ramp_step_generator_core_assert.svh"

module stepper_ramp_step_generator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [srsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srsg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  srsg_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output srsg_pkg::out_item_t                  out_data
);

  logic [23:0] interval_max;
  logic [23:0] interval_min;
  logic [15:0] start_accel;
  logic [15:0] stop_accel, stop_accel_next;
  logic [23:0] reverse_pause;
  logic [7:0]  pulse_width;
  logic        invert_dir;

  logic [srsg_pkg::COUNT_BITS-1:0] steps_left, steps_left_next;
  logic [srsg_pkg::TIMER_BITS-1:0] cur_interval, cur_interval_next;
  logic [srsg_pkg::TIMER_BITS-1:0] since_last_step, since_last_step_next;
  logic [srsg_pkg::TIMER_BITS-1:0] phase_timer, phase_timer_next;
  logic                            last_direction, last_direction_next;
  logic                            move_direction, move_direction_next;
  logic                            enabled, enabled_next;
  srsg_pkg::phase_t                phase, phase_next;

  logic [srsg_pkg::PROD_W-1:0]          prod;
  logic signed [srsg_pkg::FADE_W-1:0]   span, term, fade_s;
  logic [srsg_pkg::TIMER_BITS-1:0]      fade_val;
  logic [srsg_pkg::TIMER_BITS-1:0]      pulse_len;
  logic [srsg_pkg::COUNT_BITS-1:0]      cmd_count;

  logic                accept, go;
  srsg_pkg::out_item_t result;
  logic                skid_valid;
  srsg_pkg::out_item_t skid_data;
  logic                out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_max  <= 24'd2000;
      interval_min  <= 24'd200;
      start_accel   <= 16'd10;
      stop_accel    <= 16'd256;
      reverse_pause <= 24'd50000;
      pulse_width   <= 8'd5;
      invert_dir    <= 1'b0;
    end else if (cfg_write) begin
      case (srsg_pkg::reg_idx_t'(cfg_index))
        srsg_pkg::REG_INTERVAL_MAX:  interval_max  <= cfg_data[23:0];
        srsg_pkg::REG_INTERVAL_MIN:  interval_min  <= cfg_data[23:0];
        srsg_pkg::REG_START_ACCEL:   start_accel   <= cfg_data[15:0];
        srsg_pkg::REG_STOP_ACCEL:    stop_accel    <= cfg_data[15:0];
        srsg_pkg::REG_REVERSE_PAUSE: reverse_pause <= cfg_data[23:0];
        srsg_pkg::REG_PULSE_WIDTH:   pulse_width   <= cfg_data[7:0];
        srsg_pkg::REG_INVERT_DIR:    invert_dir    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign stop_accel_next =
    (cfg_write && srsg_pkg::reg_idx_t'(cfg_index) == srsg_pkg::REG_STOP_ACCEL) ?
    cfg_data[15:0] : stop_accel;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod <= '0;
    end else begin
      prod <= srsg_pkg::PROD_W'(steps_left_next) * srsg_pkg::PROD_W'(stop_accel_next);
    end
  end

  always_comb begin
    span   = $signed(srsg_pkg::FADE_W'(interval_max)) -
             $signed(srsg_pkg::FADE_W'(interval_min));
    term   = $signed(srsg_pkg::FADE_W'(
               ((srsg_pkg::PROD_W+1)'(prod) + (srsg_pkg::PROD_W+1)'(8'hff)) >> 8));
    fade_s = span - term;
    if (fade_s <= 0) begin
      fade_val = '0;
    end else if (fade_s > $signed(srsg_pkg::FADE_W'(srsg_pkg::TMAX))) begin
      fade_val = srsg_pkg::TMAX;
    end else begin
      fade_val = srsg_pkg::TIMER_BITS'(fade_s);
    end
  end

  assign pulse_len = (pulse_width == 8'd0) ? srsg_pkg::TIMER_BITS'(1)
                                           : srsg_pkg::TIMER_BITS'(pulse_width);
  assign cmd_count = srsg_pkg::COUNT_BITS'(in_data.step_count);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    steps_left_next      = steps_left;
    cur_interval_next    = cur_interval;
    since_last_step_next = since_last_step;
    phase_timer_next     = phase_timer;
    last_direction_next  = last_direction;
    move_direction_next  = move_direction;
    enabled_next         = enabled;
    phase_next           = phase;
    go                   = 1'b0;

    if (accept && in_data.func == srsg_pkg::FUNC_MOVE) begin
      if (phase == srsg_pkg::PH_IDLE && cmd_count != '0) begin
        steps_left_next     = cmd_count;
        move_direction_next = in_data.direction;
        phase_next          = srsg_pkg::PH_START;
      end
    end else if (accept) begin
      go = 1'b1;
      if (since_last_step != srsg_pkg::TMAX) begin
        since_last_step_next = since_last_step + srsg_pkg::TIMER_BITS'(1);
      end

      if (go && phase_next == srsg_pkg::PH_PULSE) begin
        if (phase_timer_next == '0) begin
          phase_timer_next = fade_val;
          phase_next       = srsg_pkg::PH_FADE;
        end else begin
          phase_timer_next = phase_timer_next - srsg_pkg::TIMER_BITS'(1);
          go               = 1'b0;
        end
      end

      if (go && phase_next == srsg_pkg::PH_FADE) begin
        if (phase_timer_next == '0) begin
          if (steps_left_next != '0) begin
            steps_left_next = steps_left_next - srsg_pkg::COUNT_BITS'(1);
          end
          if (steps_left_next != '0) begin
            phase_next = srsg_pkg::PH_START;
          end else begin
            phase_next = srsg_pkg::PH_IDLE;
            go         = 1'b0;
          end
        end else begin
          phase_timer_next = phase_timer_next - srsg_pkg::TIMER_BITS'(1);
          go               = 1'b0;
        end
      end

      if (go && phase_next == srsg_pkg::PH_START) begin
        if (33'(since_last_step_next) > 33'(interval_max)) begin
          cur_interval_next = srsg_pkg::tclamp(interval_max);
        end
        if (move_direction_next != last_direction_next) begin
          cur_interval_next = srsg_pkg::tclamp(interval_max);
          phase_timer_next  = srsg_pkg::tclamp(reverse_pause);
          phase_next        = srsg_pkg::PH_REV;
        end else begin
          phase_next = srsg_pkg::PH_WAIT;
        end
      end

      if (go && phase_next == srsg_pkg::PH_REV) begin
        if (phase_timer_next == '0) begin
          phase_next = srsg_pkg::PH_WAIT;
        end else begin
          phase_timer_next = phase_timer_next - srsg_pkg::TIMER_BITS'(1);
          go               = 1'b0;
        end
      end

      if (go && phase_next == srsg_pkg::PH_WAIT) begin
        if (since_last_step_next >= cur_interval_next) begin
          if (33'(cur_interval_next) > 33'(interval_min)) begin
            if (33'(cur_interval_next) > 33'(start_accel)) begin
              cur_interval_next = srsg_pkg::TIMER_BITS'(
                33'(cur_interval_next) - 33'(start_accel));
            end else begin
              cur_interval_next = '0;
            end
          end
          since_last_step_next = '0;
          last_direction_next  = move_direction_next;
          enabled_next         = 1'b1;
          phase_timer_next     = pulse_len;
          phase_next           = srsg_pkg::PH_PULSE;
        end else begin
          go = 1'b0;
        end
      end

      // entered the pulse this tick: first microsecond of high time
      if (go && phase_next == srsg_pkg::PH_PULSE) begin
        phase_timer_next = phase_timer_next - srsg_pkg::TIMER_BITS'(1);
      end
    end

    result.step_out     = (phase_next == srsg_pkg::PH_PULSE);
    result.dir_out      = enabled_next & (last_direction_next ^ invert_dir);
    result.enable_out_n = !enabled_next;
    result.busy_res     = (phase_next != srsg_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left      <= '0;
      cur_interval    <= '0;
      since_last_step <= '0;
      phase_timer     <= '0;
      last_direction  <= 1'b0;
      move_direction  <= 1'b0;
      enabled         <= 1'b0;
      phase           <= srsg_pkg::PH_IDLE;
    end else begin
      steps_left      <= steps_left_next;
      cur_interval    <= cur_interval_next;
      since_last_step <= since_last_step_next;
      phase_timer     <= phase_timer_next;
      last_direction  <= last_direction_next;
      move_direction  <= move_direction_next;
      enabled         <= enabled_next;
      phase           <= phase_next;
    end
  end

  assign in_stall = skid_valid;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!accept) begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  `SRSG_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid)
  `SRSG_ASSERT_IMP(a_step_while_busy, out_valid && out_data.step_out, out_data.busy_res)
  `SRSG_ASSERT_IMP(a_pulse_enabled, phase == srsg_pkg::PH_PULSE, enabled)
  `SRSG_ASSERT_IMP(a_idle_no_steps, phase == srsg_pkg::PH_IDLE, steps_left == '0)
  `SRSG_ASSERT_NXT(a_skid_fill, accept && out_valid && out_stall, skid_valid)

endmodule

### tb/tb_stepper_ramp_step_generator_core.sv
// Self-checking testbench for stepper_ramp_step_generator_core: directed beats, then random
// tick/move traffic over several register settings, checked against a cycle-free step predictor.
// Depends on srsg_pkg and the core RTL.
module tb_stepper_ramp_step_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import srsg_pkg::*;

  localparam int NUM_SETS    = 8;
  localparam int NUM_REGS    = 7;
  localparam int SET_BEATS   = 250;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_LIMIT = 60000;

  localparam out_item_t ST_IDLE  = '{1'b0, 1'b0, 1'b1, 1'b0};
  localparam out_item_t ST_ARMED = '{1'b0, 1'b0, 1'b1, 1'b1};
  localparam out_item_t ST_PULSE = '{1'b1, 1'b0, 1'b0, 1'b1};

  typedef struct {
    in_item_t  beat;
    int        reps;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  // step predictor state
  phase_t      gen_phase;
  logic [23:0] gen_steps, gen_interval, gen_elapsed, gen_timer;
  logic        gen_last_dir, gen_move_dir, gen_enabled;
  logic [23:0] lim_max, lim_min, rev_pause;
  logic [15:0] accel_up, accel_down;
  logic [7:0]  pulse_len;
  logic        dir_invert;

  out_item_t status_q[$];
  int        fails = 0;
  int        out_beats = 0;
  int        sent_beats = 0;
  bit        burst_in = 1'b0;
  bit        burst_out = 1'b0;

  reg_idx_t reg_order [NUM_REGS] = '{REG_INTERVAL_MAX, REG_INTERVAL_MIN, REG_START_ACCEL,
                                     REG_STOP_ACCEL, REG_REVERSE_PAUSE, REG_PULSE_WIDTH,
                                     REG_INVERT_DIR};

  logic [23:0] ramp_cfg [NUM_SETS][NUM_REGS] = '{
    '{24'd20, 24'd4, 24'd3, 24'd256, 24'd6, 24'd2, 24'hFFFFFE},
    '{24'd40, 24'd10, 24'd5, 24'd512, 24'd12, 24'd1, 24'd1},
    '{24'd8, 24'd2, 24'd1, 24'd128, 24'd0, 24'hFFFF00, 24'd0},
    '{24'd30, 24'd0, 24'd100, 24'd0, 24'd3, 24'd3, 24'd1},
    '{24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd1, 24'd0},
    '{24'd5, 24'd50, 24'd2, 24'hFFFF, 24'd4, 24'd9, 24'd1},
    '{24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'hFFFF, 24'hFFFFFF, 24'd255, 24'd1},
    '{24'd64, 24'd16, 24'd2, 24'd300, 24'd10, 24'd3, 24'd0}
  };
  bit keep_dir_set [NUM_SETS] = '{0, 0, 0, 0, 0, 0, 1, 0};
  bit long_set [NUM_SETS]     = '{0, 0, 0, 0, 0, 0, 0, 1};

  script_row_t script [8] = '{
    '{'{FUNC_TICK, 1'b0, 24'd0}, 1, 1'b1, ST_IDLE},
    '{'{FUNC_MOVE, 1'b1, 24'd0}, 1, 1'b1, ST_IDLE},
    '{'{FUNC_MOVE, 1'b0, 24'd1}, 1, 1'b1, ST_ARMED},
    '{'{FUNC_MOVE, 1'b1, 24'hFFFFFF}, 1, 1'b1, ST_ARMED},
    '{'{FUNC_TICK, 1'b1, 24'hFFFFFF}, 2, 1'b1, ST_PULSE},
    '{'{FUNC_TICK, 1'b0, 24'd0}, 17, 1'b0, ST_IDLE},
    '{'{FUNC_MOVE, 1'b1, 24'd2}, 1, 1'b0, ST_IDLE},
    '{'{FUNC_TICK, 1'b0, 24'd0}, 1, 1'b0, ST_IDLE}
  };

  stepper_ramp_step_generator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void ramp_reset();
    lim_max = 24'd2000;
    lim_min = 24'd200;
    accel_up = 16'd10;
    accel_down = 16'd256;
    rev_pause = 24'd50000;
    pulse_len = 8'd5;
    dir_invert = 1'b0;
    gen_phase = PH_IDLE;
    gen_steps = '0;
    gen_interval = '0;
    gen_elapsed = '0;
    gen_timer = '0;
    gen_last_dir = 1'b0;
    gen_move_dir = 1'b0;
    gen_enabled = 1'b0;
  endfunction

  function automatic void ramp_write(reg_idx_t idx, logic [23:0] v);
    case (idx)
      REG_INTERVAL_MAX:  lim_max = v;
      REG_INTERVAL_MIN:  lim_min = v;
      REG_START_ACCEL:   accel_up = v[15:0];
      REG_STOP_ACCEL:    accel_down = v[15:0];
      REG_REVERSE_PAUSE: rev_pause = v;
      REG_PULSE_WIDTH:   pulse_len = v[7:0];
      REG_INVERT_DIR:    dir_invert = v[0];
      default: ;
    endcase
  endfunction

  // span minus the rounded-up deceleration term, floored at zero
  function automatic logic [23:0] decel_wait();
    logic [40:0]        prod;
    logic signed [42:0] w;
    prod = 41'(gen_steps) * 41'(accel_down) + 41'd255;
    w = $signed({19'b0, lim_max}) - $signed({19'b0, lim_min}) - $signed({10'b0, prod[40:8]});
    return (w > 0) ? w[23:0] : 24'd0;
  endfunction

  function automatic void ramp_tick();
    bit go;
    go = 1'b1;
    if (gen_elapsed != TMAX) gen_elapsed = gen_elapsed + 24'd1;
    while (go) begin
      case (gen_phase)
        PH_START: begin
          if (gen_elapsed > lim_max) gen_interval = lim_max;
          if (gen_move_dir != gen_last_dir) begin
            gen_interval = lim_max;
            gen_timer = rev_pause;
            gen_phase = PH_REV;
          end else begin
            gen_phase = PH_WAIT;
          end
        end
        PH_REV: begin
          if (gen_timer == 0) gen_phase = PH_WAIT;
          else begin
            gen_timer = gen_timer - 24'd1;
            go = 1'b0;
          end
        end
        PH_WAIT: begin
          if (gen_elapsed >= gen_interval) begin
            if (gen_interval > lim_min)
              gen_interval = (gen_interval > 24'(accel_up)) ? gen_interval - 24'(accel_up) : '0;
            gen_elapsed = '0;
            gen_last_dir = gen_move_dir;
            gen_enabled = 1'b1;
            gen_timer = (pulse_len == 0) ? 24'd1 : 24'(pulse_len);
            gen_phase = PH_PULSE;
          end else begin
            go = 1'b0;
          end
        end
        PH_PULSE: begin
          if (gen_timer == 0) begin
            gen_timer = decel_wait();
            gen_phase = PH_FADE;
          end else begin
            gen_timer = gen_timer - 24'd1;
            go = 1'b0;
          end
        end
        PH_FADE: begin
          if (gen_timer == 0) begin
            if (gen_steps != 0) gen_steps = gen_steps - 24'd1;
            if (gen_steps != 0) gen_phase = PH_START;
            else begin
              gen_phase = PH_IDLE;
              go = 1'b0;
            end
          end else begin
            gen_timer = gen_timer - 24'd1;
            go = 1'b0;
          end
        end
        default: begin
          gen_phase = PH_IDLE;
          go = 1'b0;
        end
      endcase
    end
  endfunction

  function automatic out_item_t ramp_predict(in_item_t b);
    out_item_t r;
    if (b.func == FUNC_MOVE) begin
      if (gen_phase == PH_IDLE && b.step_count != 0) begin
        gen_steps = b.step_count;
        gen_move_dir = b.direction;
        gen_phase = PH_START;
      end
    end else begin
      ramp_tick();
    end
    r.step_out = (gen_phase == PH_PULSE);
    r.dir_out = gen_enabled ? (gen_last_dir ^ dir_invert) : 1'b0;
    r.enable_out_n = !gen_enabled;
    r.busy_res = (gen_phase != PH_IDLE);
    return r;
  endfunction

  // keep moves short unless the set allows endless ones; busy moves carry any count
  function automatic in_item_t pick_beat(bit keep_dir, bit long_moves);
    in_item_t b;
    int       r;
    b.direction = 1'($urandom_range(0, 1));
    b.step_count = 24'($urandom());
    if (gen_phase == PH_IDLE) begin
      b.func = ($urandom_range(0, 99) < 40) ? FUNC_MOVE : FUNC_TICK;
      if (b.func == FUNC_MOVE) begin
        r = $urandom_range(0, 9);
        if (r == 0) b.step_count = '0;
        else if (!(long_moves && r >= 8)) b.step_count = 24'($urandom_range(1, 6));
        if (keep_dir) b.direction = gen_last_dir;
      end
    end else begin
      b.func = ($urandom_range(0, 99) < 10) ? FUNC_MOVE : FUNC_TICK;
    end
    return b;
  endfunction

  task automatic send_beat(in_item_t b, bit typed, out_item_t want);
    int        gap;
    out_item_t pred;
    if (sent_beats % 64 == 0) burst_in = ($urandom_range(0, 3) == 0);
    gap = burst_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = ramp_predict(b);
    status_q.push_back(typed ? want : pred);
    sent_beats++;
    @(negedge clk);
  endtask

  task automatic load_set(int s);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_index <= reg_order[i];
      cfg_data <= ramp_cfg[s][i];
      cfg_write <= 1'b1;
      ramp_write(reg_order[i], ramp_cfg[s][i]);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic flag_mismatch(string what, out_item_t want, out_item_t got);
    fails++;
    if (fails <= 10)
      $display("%s at out beat %0d: expected %b got %b (step dir en_n busy)",
               what, out_beats, want, got);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        flag_mismatch("unexpected beat", '0, out_data);
      end else begin
        want = status_q.pop_front();
        if (out_data.step_out !== want.step_out || out_data.dir_out !== want.dir_out ||
            out_data.enable_out_n !== want.enable_out_n ||
            out_data.busy_res !== want.busy_res)
          flag_mismatch("mismatch", want, out_data);
      end
      out_beats++;
    end
  end

  initial begin : receiver
    int n;
    int taken;
    bit held_a;
    bit held_b;
    taken = 0;
    held_a = 1'b0;
    held_b = 1'b0;
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) burst_out = ($urandom_range(0, 3) == 0);
      n = burst_out ? 0 : $urandom_range(0, 14);
      if (!held_a && out_beats >= 300) begin
        held_a = 1'b1;
        n = 400;
      end else if (!held_b && out_beats >= 1500) begin
        held_b = 1'b1;
        n = 400;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_stepper_ramp_step_generator_core NOT OK");
    $finish;
  end

  initial begin : stimulus
    int guard;
    ramp_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    load_set(0);

    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++)
        send_beat(script[i].beat, script[i].typed, script[i].want);
    end

    for (int s = 0; s < NUM_SETS; s++) begin
      if (s != 0) begin
        // hold off until the pipe is empty before touching registers
        in_valid <= 1'b0;
        wait (status_q.size() == 0);
        repeat (4) @(negedge clk);
        load_set(s);
      end
      for (int k = 0; k < SET_BEATS; k++)
        send_beat(pick_beat(keep_dir_set[s], long_set[s]), 1'b0, '0);
      if (!long_set[s]) begin
        guard = 0;
        while (gen_phase != PH_IDLE && guard < DRAIN_LIMIT) begin
          send_beat('{FUNC_TICK, 1'($urandom_range(0, 1)), 24'($urandom())}, 1'b0, '0);
          guard++;
        end
      end
    end

    in_valid <= 1'b0;
    wait (status_q.size() == 0);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("tb_stepper_ramp_step_generator_core OK");
    else $display("tb_stepper_ramp_step_generator_core NOT OK");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/srsg_pkg.sv
rtl/core/stepper_ramp_step_generator_core.sv
tb/tb_stepper_ramp_step_generator_core.sv
